// ===== rtl/core/lde_pkg.sv =====
`default_nettype none

package lde_pkg;

    // Operation codes carried in a request.
    typedef enum logic [1:0] {
        OP_MOVETO = 2'd0,
        OP_LINETO = 2'd1,
        OP_STEP   = 2'd2,
        OP_PEN    = 2'd3
    } op_t;

    // Status codes returned with each result.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPEN = 2'd1,
        ST_NOLINE = 2'd2,
        ST_BUSY   = 2'd3
    } status_t;

    // Pen colour after reset (white) and the lowest pen a context may select.
    localparam logic [7:0] PEN_RESET = 8'd15;
    localparam logic [7:0] PEN_MIN   = 8'd16;

    // One drawing request.
    typedef struct packed {
        op_t                operation;
        logic [3:0]         context_req;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [7:0]         pen_index;
    } req_t;

    // One drawing result.
    typedef struct packed {
        logic       has_pixel;
        logic [15:0] pixel_address;
        logic [7:0] pixel_colour;
        logic       last_pixel;
        status_t    status;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/line_draw_engine.sv =====
`default_nettype none

// Line drawing engine. Each request yields exactly one result, in order. A lineto
// request returns the first pixel of the line and every step request during a line
// returns the next pixel, one Bresenham iteration per request; the walk state is
// updated in the same cycle, so the engine sustains one request per clock while the
// result side does not stall. A request passes an input register and then the
// result register before its result is offered. Pixel addresses are y*SCREEN_W+x,
// truncated to 16 bits. Requests other than step return a busy status while a line
// is still being walked.
module line_draw_engine #(
    parameter int SCREEN_W     = 320,
    parameter int SCREEN_H     = 200,
    parameter int NUM_CONTEXTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire lde_pkg::req_t cmd,
    output logic               result_valid,
    input  wire logic          result_stall,
    output lde_pkg::rsp_t      result
);
    import lde_pkg::*;

    logic  in_valid_reg, in_valid_next;
    req_t  in_item_reg;
    logic  out_valid_reg, out_valid_next;
    rsp_t  out_item_reg;
    rsp_t  core_rsp;
    logic  advance, accept;

    // A held request moves on when the result register is free or being taken.
    assign advance   = in_valid_reg && (!out_valid_reg || !result_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    lde_core #(
        .SCREEN_W     (SCREEN_W),
        .SCREEN_H     (SCREEN_H),
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (in_item_reg),
        .rsp   (core_rsp)
    );

    // Valid flags for both registers.
    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= cmd;
        if (advance)
            out_item_reg <= core_rsp;
    end

endmodule

`default_nettype wire

// ===== rtl/core/lde_core.sv =====
`default_nettype none

module lde_core #(
    parameter int SCREEN_W     = 320,
    parameter int SCREEN_H     = 200,
    parameter int NUM_CONTEXTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire lde_pkg::req_t req,
    output lde_pkg::rsp_t      rsp
);
    import lde_pkg::*;

    localparam int XW = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1;
    localparam int YW = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
    localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int EW = ((XW > YW) ? XW : YW) + 3;

    // Per-context pen state.
    logic [XW-1:0] pos_x_reg [NUM_CONTEXTS];
    logic [YW-1:0] pos_y_reg [NUM_CONTEXTS];
    logic [7:0]    pen_reg   [NUM_CONTEXTS];

    // Line walker state.
    logic                 line_active_reg, line_active_next;
    logic [XW-1:0]        walk_x_reg, walk_x_next;
    logic [YW-1:0]        walk_y_reg, walk_y_next;
    logic [XW-1:0]        end_x_reg, end_x_next;
    logic [YW-1:0]        end_y_reg, end_y_next;
    logic signed [EW-1:0] error_term_reg, error_term_next;
    logic [XW-1:0]        span_x_reg, span_x_next;
    logic signed [YW:0]   span_y_neg_reg, span_y_neg_next;
    logic                 dir_x_neg_reg, dir_x_neg_next;
    logic                 dir_y_neg_reg, dir_y_neg_next;
    logic [7:0]           line_pen_reg, line_pen_next;

    logic [CW-1:0]        ctx;
    logic [XW-1:0]        cx, rd_x, dx, step_x, emit_x;
    logic [YW-1:0]        cy, rd_y, dy, step_y, emit_y;
    logic [7:0]           rd_pen;
    logic signed [EW:0]   e2;
    logic signed [EW-1:0] sx_ext, sy_ext, err_step;
    logic                 move_x, move_y;
    logic                 pos_we, pen_we;
    logic [31:0]          addr_full;

    // Saturate the context and clamp the coordinates to the screen.
    always_comb
    begin
        if (32'(req.context_req) > 32'(NUM_CONTEXTS - 1))
            ctx = CW'(NUM_CONTEXTS - 1);
        else
            ctx = req.context_req[CW-1:0];

        if (req.coord_x < 16'sd0)
            cx = '0;
        else if (req.coord_x > 16'(SCREEN_W - 1))
            cx = XW'(SCREEN_W - 1);
        else
            cx = req.coord_x[XW-1:0];

        if (req.coord_y < 16'sd0)
            cy = '0;
        else if (req.coord_y > 16'(SCREEN_H - 1))
            cy = YW'(SCREEN_H - 1);
        else
            cy = req.coord_y[YW-1:0];
    end

    assign rd_x   = pos_x_reg[ctx];
    assign rd_y   = pos_y_reg[ctx];
    assign rd_pen = pen_reg[ctx];

    // Spans for a new line from the stored position to the clamped endpoint.
    assign dx = (cx > rd_x) ? cx - rd_x : rd_x - cx;
    assign dy = (cy > rd_y) ? cy - rd_y : rd_y - cy;

    // One Bresenham iteration from the current walk state.
    always_comb
    begin
        sx_ext = EW'($signed({1'b0, span_x_reg}));
        sy_ext = EW'(span_y_neg_reg);
        e2     = {error_term_reg, 1'b0};
        move_x = (e2 >= (EW+1)'(sy_ext));
        move_y = (e2 <= (EW+1)'(sx_ext));
        err_step = error_term_reg + (move_x ? sy_ext : '0) + (move_y ? sx_ext : '0);
        step_x = walk_x_reg;
        step_y = walk_y_reg;
        if (move_x)
            step_x = dir_x_neg_reg ? walk_x_reg - 1'b1 : walk_x_reg + 1'b1;
        if (move_y)
            step_y = dir_y_neg_reg ? walk_y_reg - 1'b1 : walk_y_reg + 1'b1;
    end

    // Decode the request into a result and the next state.
    always_comb
    begin
        line_active_next = line_active_reg;
        walk_x_next      = walk_x_reg;
        walk_y_next      = walk_y_reg;
        end_x_next       = end_x_reg;
        end_y_next       = end_y_reg;
        error_term_next  = error_term_reg;
        span_x_next      = span_x_reg;
        span_y_neg_next  = span_y_neg_reg;
        dir_x_neg_next   = dir_x_neg_reg;
        dir_y_neg_next   = dir_y_neg_reg;
        line_pen_next    = line_pen_reg;
        pos_we           = 1'b0;
        pen_we           = 1'b0;
        emit_x           = step_x;
        emit_y           = step_y;
        rsp              = '0;
        rsp.status       = ST_OK;

        case (req.operation)
            OP_STEP:
            begin
                if (!line_active_reg)
                    rsp.status = ST_NOLINE;
                else
                begin
                    walk_x_next     = step_x;
                    walk_y_next     = step_y;
                    error_term_next = err_step;
                    rsp.has_pixel   = 1'b1;
                    rsp.pixel_colour = line_pen_reg;
                    rsp.last_pixel  = (step_x == end_x_reg) && (step_y == end_y_reg);
                    line_active_next = !rsp.last_pixel;
                end
            end
            OP_MOVETO:
            begin
                if (line_active_reg)
                    rsp.status = ST_BUSY;
                else
                    pos_we = 1'b1;
            end
            OP_PEN:
            begin
                if (line_active_reg)
                    rsp.status = ST_BUSY;
                else if (req.pen_index < PEN_MIN)
                    rsp.status = ST_BADPEN;
                else
                    pen_we = 1'b1;
            end
            OP_LINETO:
            begin
                if (line_active_reg)
                    rsp.status = ST_BUSY;
                else
                begin
                    pos_we          = 1'b1;
                    walk_x_next     = rd_x;
                    walk_y_next     = rd_y;
                    end_x_next      = cx;
                    end_y_next      = cy;
                    span_x_next     = dx;
                    span_y_neg_next = -$signed({1'b0, dy});
                    dir_x_neg_next  = !(rd_x < cx);
                    dir_y_neg_next  = !(rd_y < cy);
                    error_term_next = EW'($signed({1'b0, dx})) - EW'($signed({1'b0, dy}));
                    line_pen_next   = rd_pen;
                    emit_x          = rd_x;
                    emit_y          = rd_y;
                    rsp.has_pixel   = 1'b1;
                    rsp.pixel_colour = rd_pen;
                    rsp.last_pixel  = (rd_x == cx) && (rd_y == cy);
                    line_active_next = !rsp.last_pixel;
                end
            end
            default:
            begin
                rsp.status = ST_OK;
            end
        endcase

        addr_full = 32'(emit_y) * 32'(SCREEN_W) + 32'(emit_x);
        if (rsp.has_pixel)
            rsp.pixel_address = addr_full[15:0];
    end

    // Context arrays.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CONTEXTS; i++)
            begin
                pos_x_reg[i] <= '0;
                pos_y_reg[i] <= '0;
                pen_reg[i]   <= PEN_RESET;
            end
        end
        else if (fire)
        begin
            if (pos_we)
            begin
                pos_x_reg[ctx] <= cx;
                pos_y_reg[ctx] <= cy;
            end
            if (pen_we)
                pen_reg[ctx] <= req.pen_index;
        end
    end

    // Walker registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            walk_x_reg      <= '0;
            walk_y_reg      <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            error_term_reg  <= '0;
            span_x_reg      <= '0;
            span_y_neg_reg  <= '0;
            dir_x_neg_reg   <= 1'b0;
            dir_y_neg_reg   <= 1'b0;
            line_pen_reg    <= '0;
        end
        else if (fire)
        begin
            line_active_reg <= line_active_next;
            walk_x_reg      <= walk_x_next;
            walk_y_reg      <= walk_y_next;
            end_x_reg       <= end_x_next;
            end_y_reg       <= end_y_next;
            error_term_reg  <= error_term_next;
            span_x_reg      <= span_x_next;
            span_y_neg_reg  <= span_y_neg_next;
            dir_x_neg_reg   <= dir_x_neg_next;
            dir_y_neg_reg   <= dir_y_neg_next;
            line_pen_reg    <= line_pen_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_line_draw_engine.sv =====
module tb_line_draw_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import lde_pkg::*;

    localparam int SCREEN_W     = 320;
    localparam int SCREEN_H     = 200;
    localparam int NUM_CONTEXTS = 16;
    localparam int RANDOM_ITEMS = 1525;
    localparam int HOLD_CYCLES  = 120;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk          = 1'b0;
    logic rst_n        = 1'b0;
    logic cmd_valid    = 1'b0;
    logic cmd_stall;
    req_t cmd          = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    rsp_t result;

    rsp_t expected_results[$];
    int   failures       = 0;
    int   accepted_count = 0;
    int   stall_left     = 0;
    bit   hold_off       = 1'b0;
    bit   send_paced     = 1'b1;
    bit   recv_paced     = 1'b1;

    // Shadow of the drawing state: per-context position and ink, and the line walk.
    logic [8:0]        ctx_x   [NUM_CONTEXTS];
    logic [7:0]        ctx_y   [NUM_CONTEXTS];
    logic [7:0]        ctx_ink [NUM_CONTEXTS];
    bit                drawing;
    logic [8:0]        cur_x;
    logic [8:0]        dest_x;
    logic [7:0]        cur_y;
    logic [7:0]        dest_y;
    logic signed [10:0] bres_err;
    logic [8:0]        run_x;
    logic signed [8:0] rise_neg;
    bit                x_falls;
    bit                y_falls;
    logic [7:0]        line_ink;

    line_draw_engine #(
        .SCREEN_W     (SCREEN_W),
        .SCREEN_H     (SCREEN_H),
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_draw_state();
        for (int i = 0; i < NUM_CONTEXTS; i++)
        begin
            ctx_x[i]   = '0;
            ctx_y[i]   = '0;
            ctx_ink[i] = PEN_RESET;
        end
        drawing  = 1'b0;
        cur_x    = '0;
        cur_y    = '0;
        dest_x   = '0;
        dest_y   = '0;
        bres_err = '0;
        run_x    = '0;
        rise_neg = '0;
        x_falls  = 1'b0;
        y_falls  = 1'b0;
        line_ink = '0;
    endfunction

    function automatic int clamp_coord(logic signed [15:0] v, int limit);
        if (v < 0)
            return 0;
        if (int'(v) > limit - 1)
            return limit - 1;
        return int'(v);
    endfunction

    // Pixel at the current walk position; reaching the endpoint ends the line.
    function automatic rsp_t walk_pixel();
        rsp_t p;
        int   addr;
        addr            = int'(cur_y) * SCREEN_W + int'(cur_x);
        p               = '0;
        p.has_pixel     = 1'b1;
        p.pixel_address = addr[15:0];
        p.pixel_colour  = line_ink;
        p.last_pixel    = (cur_x == dest_x) && (cur_y == dest_y);
        p.status        = ST_OK;
        if (p.last_pixel)
            drawing = 1'b0;
        return p;
    endfunction

    // Expected result of one request, updating the shadow state.
    function automatic rsp_t draw_predict(req_t r);
        rsp_t p;
        int   ctx;
        int   tx;
        int   ty;
        int   sx;
        int   sy;
        int   dx;
        int   dy;
        int   err;
        int   e2;
        p   = '0;
        ctx = int'(r.context_req);
        if (ctx > NUM_CONTEXTS - 1)
            ctx = NUM_CONTEXTS - 1;
        tx = clamp_coord(r.coord_x, SCREEN_W);
        ty = clamp_coord(r.coord_y, SCREEN_H);

        if (r.operation == OP_STEP)
        begin
            if (!drawing)
                p.status = ST_NOLINE;
            else
            begin
                // One Bresenham iteration, both axes may advance.
                err = int'(bres_err);
                e2  = 2 * err;
                if (e2 >= int'(rise_neg))
                begin
                    err   = err + int'(rise_neg);
                    cur_x = x_falls ? cur_x - 9'd1 : cur_x + 9'd1;
                end
                if (e2 <= int'(run_x))
                begin
                    err   = err + int'(run_x);
                    cur_y = y_falls ? cur_y - 8'd1 : cur_y + 8'd1;
                end
                bres_err = 11'(err);
                p = walk_pixel();
            end
        end
        else if (drawing)
            p.status = ST_BUSY;
        else if (r.operation == OP_MOVETO)
        begin
            ctx_x[ctx] = 9'(tx);
            ctx_y[ctx] = 8'(ty);
            p.status   = ST_OK;
        end
        else if (r.operation == OP_PEN)
        begin
            if (r.pen_index < PEN_MIN)
                p.status = ST_BADPEN;
            else
            begin
                ctx_ink[ctx] = r.pen_index;
                p.status     = ST_OK;
            end
        end
        else
        begin
            // Line start: walk from the stored position, which moves to the endpoint.
            sx         = int'(ctx_x[ctx]);
            sy         = int'(ctx_y[ctx]);
            dx         = (tx > sx) ? tx - sx : sx - tx;
            dy         = (ty > sy) ? ty - sy : sy - ty;
            run_x      = 9'(dx);
            rise_neg   = 9'(-dy);
            bres_err   = 11'(dx - dy);
            x_falls    = !(sx < tx);
            y_falls    = !(sy < ty);
            cur_x      = 9'(sx);
            cur_y      = 8'(sy);
            dest_x     = 9'(tx);
            dest_y     = 8'(ty);
            line_ink   = ctx_ink[ctx];
            ctx_x[ctx] = 9'(tx);
            ctx_y[ctx] = 8'(ty);
            drawing    = 1'b1;
            p = walk_pixel();
        end
        return p;
    endfunction

    // Mostly well-formed drawing: short lines walked to the end, some noise.
    function automatic req_t random_request();
        req_t r;
        int   ctx;
        int   pick;
        r.operation   = op_t'($urandom_range(0, 3));
        r.context_req = 4'($urandom);
        r.coord_x     = 16'($urandom);
        r.coord_y     = 16'($urandom);
        r.pen_index   = 8'($urandom);
        ctx = int'(r.context_req);
        if (ctx > NUM_CONTEXTS - 1)
            ctx = NUM_CONTEXTS - 1;
        pick = $urandom_range(0, 99);
        if (drawing)
        begin
            if (pick >= 7)
                r.operation = OP_STEP;
        end
        else if (pick < 20)
        begin
            r.operation = OP_MOVETO;
            if ($urandom_range(0, 1) != 0)
            begin
                r.coord_x = 16'($urandom_range(0, SCREEN_W - 1));
                r.coord_y = 16'($urandom_range(0, SCREEN_H - 1));
            end
        end
        else if (pick < 62)
        begin
            r.operation = OP_LINETO;
            if ($urandom_range(0, 19) != 0)
            begin
                r.coord_x = 16'(int'(ctx_x[ctx]) + int'($urandom_range(0, 24)) - 12);
                r.coord_y = 16'(int'(ctx_y[ctx]) + int'($urandom_range(0, 24)) - 12);
            end
        end
        else if (pick < 88)
        begin
            r.operation = OP_PEN;
            if ($urandom_range(0, 3) != 0)
                r.pen_index = 8'($urandom_range(16, 255));
        end
        else
            r.operation = OP_STEP;
        return r;
    endfunction

    function automatic req_t mk_req(op_t op, int ctx, int x, int y, int ink);
        req_t r;
        r.operation   = op;
        r.context_req = 4'(ctx);
        r.coord_x     = 16'(x);
        r.coord_y     = 16'(y);
        r.pen_index   = 8'(ink);
        return r;
    endfunction

    function automatic rsp_t mk_rsp(bit pix, int addr, int colour, bit last, status_t st);
        rsp_t p;
        p.has_pixel     = pix;
        p.pixel_address = 16'(addr);
        p.pixel_colour  = 8'(colour);
        p.last_pixel    = last;
        p.status        = st;
        return p;
    endfunction

    function automatic dir_row_t typed_row(req_t r, rsp_t want);
        dir_row_t row;
        row.req   = r;
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t open_row(req_t r);
        dir_row_t row;
        row.req   = r;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Offer one request, after a random gap while sends are paced, and hold it until it is taken.
    task automatic send_request(input req_t r, input rsp_t want);
        int gap;
        gap = send_paced ? $urandom_range(0, 10) : 0;
        expected_results.push_back(want);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= r;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        accepted_count++;
        if ($urandom_range(0, 49) == 0)
            send_paced = !send_paced;
    endtask

    task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
        failures++;
        if (failures <= 10)
            $display("%0t %s: expected pix=%0d addr=%0d col=%0d last=%0d st=%0d, got pix=%0d addr=%0d col=%0d last=%0d st=%0d",
                     $realtime, what,
                     want.has_pixel, want.pixel_address, want.pixel_colour,
                     want.last_pixel, want.status,
                     got.has_pixel, got.pixel_address, got.pixel_colour,
                     got.last_pixel, got.status);
    endtask

    // Result side: stall for a drawn number of cycles after each result while receives are paced, or during the hold.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
            result_stall <= hold_off;
    end

    // Compare each taken result with the oldest pending expectation.
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                note_failure("result with nothing pending", '0, result);
            else
            begin
                want = expected_results.pop_front();
                if (result.has_pixel !== want.has_pixel ||
                    result.pixel_address !== want.pixel_address ||
                    result.pixel_colour !== want.pixel_colour ||
                    result.last_pixel !== want.last_pixel ||
                    result.status !== want.status)
                    note_failure("result mismatch", want, result);
            end
            stall_left <= recv_paced ? $urandom_range(0, 10) : 0;
            if ($urandom_range(0, 49) == 0)
                recv_paced <= !recv_paced;
        end
    end

    // Long result hold-off so the engine fills up and stalls its request side.
    initial
    begin : long_hold
        wait (accepted_count >= 400);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t rows[$];
        rsp_t     want;
        req_t     r;
        clear_draw_state();

        // Directed table: pen limits, coordinate extremes, degenerate lines,
        // busy refusals, step with no line, and lines in several directions.
        rows = '{
            typed_row(mk_req(OP_STEP, 0, 0, 0, 0), mk_rsp(0, 0, 0, 0, ST_NOLINE)),
            typed_row(mk_req(OP_PEN, 0, 0, 0, 15), mk_rsp(0, 0, 0, 0, ST_BADPEN)),
            typed_row(mk_req(OP_PEN, 0, 0, 0, 0), mk_rsp(0, 0, 0, 0, ST_BADPEN)),
            typed_row(mk_req(OP_PEN, 0, 0, 0, 16), mk_rsp(0, 0, 0, 0, ST_OK)),
            typed_row(mk_req(OP_PEN, 15, 0, 0, 255), mk_rsp(0, 0, 0, 0, ST_OK)),
            typed_row(mk_req(OP_MOVETO, 0, -32768, -32768, 0), mk_rsp(0, 0, 0, 0, ST_OK)),
            typed_row(mk_req(OP_LINETO, 0, 0, 0, 0), mk_rsp(1, 0, 16, 1, ST_OK)),
            typed_row(mk_req(OP_MOVETO, 15, 32767, 32767, 0), mk_rsp(0, 0, 0, 0, ST_OK)),
            typed_row(mk_req(OP_LINETO, 15, 32767, 32767, 255),
                      mk_rsp(1, 63999, 255, 1, ST_OK)),
            open_row(mk_req(OP_LINETO, 3, 2, -5, 0)),
            typed_row(mk_req(OP_MOVETO, 3, 100, 100, 0), mk_rsp(0, 0, 0, 0, ST_BUSY)),
            typed_row(mk_req(OP_PEN, 3, 0, 0, 200), mk_rsp(0, 0, 0, 0, ST_BUSY)),
            typed_row(mk_req(OP_LINETO, 3, 50, 50, 0), mk_rsp(0, 0, 0, 0, ST_BUSY)),
            open_row(mk_req(OP_STEP, 3, 0, 0, 0)),
            open_row(mk_req(OP_STEP, 9, -1, -1, 255)),
            typed_row(mk_req(OP_STEP, 3, 0, 0, 0), mk_rsp(0, 0, 0, 0, ST_NOLINE)),
            open_row(mk_req(OP_LINETO, 3, 0, 3, 0)),
            open_row(mk_req(OP_STEP, 3, 0, 0, 0)),
            open_row(mk_req(OP_STEP, 3, 0, 0, 0)),
            open_row(mk_req(OP_STEP, 3, 0, 0, 0)),
            typed_row(mk_req(OP_MOVETO, 7, -1, 32767, 255), mk_rsp(0, 0, 0, 0, ST_OK)),
            open_row(mk_req(OP_LINETO, 7, 1, 196, 0)),
            open_row(mk_req(OP_STEP, 7, 0, 0, 0)),
            open_row(mk_req(OP_STEP, 7, 0, 0, 0)),
            open_row(mk_req(OP_STEP, 7, 0, 0, 0))
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            want = draw_predict(rows[i].req);
            if (rows[i].typed)
                want = rows[i].want;
            send_request(rows[i].req, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Once, withdraw the request and let the engine drain completely.
            if (n == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                wait (expected_results.size() == 0);
            end
            r = random_request();
            send_request(r, draw_predict(r));
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
